[sv/sasr_pkg.sv]
// Shared types and constants for the servo angle slew ramp.
// Used by sasr_cfg, sasr_step and servo_angle_slew_ramp; no dependencies.
package sasr_pkg;

  localparam int unsigned DELAY_BITS = 16;
  localparam int unsigned DelayRegW = 16;
  localparam int unsigned CmpW = (DELAY_BITS > DelayRegW) ? DELAY_BITS : DelayRegW;

  localparam int unsigned AngleW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgMinAngle     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxAngle     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDefaultAngle = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgReverseDir   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStepSize     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStepDelay    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgHomeSmooth   = 3'd6;

  localparam logic [AngleW-1:0] RstMinAngle     = 8'd0;
  localparam logic [AngleW-1:0] RstMaxAngle     = 8'd180;
  localparam logic [AngleW-1:0] RstDefaultAngle = 8'd90;
  localparam logic [AngleW-1:0] RstStepSize     = 8'd2;
  localparam logic [DelayRegW-1:0] RstStepDelay = 16'd12;
  // The default angle already lies inside the reset range, so it is the start angle.
  localparam logic [AngleW-1:0] RstAngle        = RstDefaultAngle;

  typedef enum logic [1:0] {
    ModeTick   = 2'd0,
    ModeSmooth = 2'd1,
    ModeJump   = 2'd2,
    ModeHome   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [AngleW-1:0]    min_angle;
    logic [AngleW-1:0]    max_angle;
    logic [AngleW-1:0]    default_angle;
    logic                 reverse_dir;
    logic [AngleW-1:0]    step_size;
    logic [DelayRegW-1:0] step_delay_ms;
    logic                 home_smooth;
  } cfg_t;

  typedef struct packed {
    logic [AngleW-1:0]     current_angle;
    logic [AngleW-1:0]     target_angle;
    logic                  moving_flag;
    logic [DELAY_BITS-1:0] elapsed_ms;
  } state_t;

  typedef struct packed {
    logic [AngleW-1:0] drive_angle;
    logic [AngleW-1:0] now_angle;
    logic              is_moving;
    logic              servo_written;
    logic              motion_done;
  } result_t;

endpackage

[sv/sasr_cfg.sv]
// Configuration register file of the servo angle slew ramp.
// Depends on sasr_pkg for the register indexes, reset values and cfg_t.
module sasr_cfg import sasr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinAngle:     cfg_d.min_angle     = cfg_wdata_i[AngleW-1:0];
        CfgMaxAngle:     cfg_d.max_angle     = cfg_wdata_i[AngleW-1:0];
        CfgDefaultAngle: cfg_d.default_angle = cfg_wdata_i[AngleW-1:0];
        CfgReverseDir:   cfg_d.reverse_dir   = cfg_wdata_i[0];
        CfgStepSize:     cfg_d.step_size     = cfg_wdata_i[AngleW-1:0];
        CfgStepDelay:    cfg_d.step_delay_ms = cfg_wdata_i[DelayRegW-1:0];
        CfgHomeSmooth:   cfg_d.home_smooth   = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_angle     <= RstMinAngle;
      cfg_q.max_angle     <= RstMaxAngle;
      cfg_q.default_angle <= RstDefaultAngle;
      cfg_q.reverse_dir   <= 1'b0;
      cfg_q.step_size     <= RstStepSize;
      cfg_q.step_delay_ms <= RstStepDelay;
      cfg_q.home_smooth   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/sasr_step.sv]
// Next-state and result logic for one beat of the servo angle slew ramp.
// Depends on sasr_pkg for mode_e, cfg_t, state_t and result_t.
module sasr_step import sasr_pkg::*; (
  input  cfg_t              cfg_i,
  input  state_t            state_i,
  input  logic [1:0]        mode_i,
  input  logic [AngleW-1:0] req_angle_i,
  output state_t            state_o,
  output result_t           result_o
);

  function automatic logic [AngleW-1:0] clamp_angle(input logic [AngleW-1:0] x,
                                                    input logic [AngleW-1:0] lo,
                                                    input logic [AngleW-1:0] hi);
    logic [AngleW-1:0] r;
    if (x < lo) begin
      r = lo;
    end else if (x > hi) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

  mode_e                 mode;
  logic [AngleW-1:0]     cur, tgt, req_a, home_d, home_a;
  logic [AngleW:0]       up_sum, dn_lim;
  logic [AngleW-1:0]     up_val, dn_val, stepped;
  logic [DELAY_BITS-1:0] elapsed_inc;
  logic                  step_due;
  logic                  written, done;
  state_t                st;
  logic signed [AngleW+1:0] mirror;

  assign mode   = mode_e'(mode_i);
  assign cur    = state_i.current_angle;
  assign tgt    = state_i.target_angle;
  assign req_a  = clamp_angle(req_angle_i, cfg_i.min_angle, cfg_i.max_angle);
  assign home_d = clamp_angle(cfg_i.default_angle, cfg_i.min_angle, cfg_i.max_angle);
  assign home_a = clamp_angle(home_d, cfg_i.min_angle, cfg_i.max_angle);

  assign elapsed_inc = (state_i.elapsed_ms != '1) ? state_i.elapsed_ms + 1'b1
                                                  : state_i.elapsed_ms;
  assign step_due = CmpW'(elapsed_inc) >= CmpW'(cfg_i.step_delay_ms);

  assign up_sum  = {1'b0, cur} + {1'b0, cfg_i.step_size};
  assign up_val  = (up_sum < {1'b0, tgt}) ? up_sum[AngleW-1:0] : tgt;
  assign dn_lim  = {1'b0, tgt} + {1'b0, cfg_i.step_size};
  assign dn_val  = ({1'b0, cur} >= dn_lim) ? (cur - cfg_i.step_size) : tgt;
  assign stepped = (cur < tgt) ? up_val : ((cur > tgt) ? dn_val : cur);

  always_comb begin
    st      = state_i;
    written = 1'b0;
    done    = 1'b0;
    unique case (mode)
      ModeTick: begin
        if (state_i.moving_flag) begin
          st.elapsed_ms = elapsed_inc;
          if (step_due) begin
            st.current_angle = stepped;
            st.elapsed_ms    = '0;
            written          = 1'b1;
            if (stepped == tgt) begin
              st.moving_flag = 1'b0;
              done           = 1'b1;
            end
          end
        end
      end
      ModeSmooth: begin
        if (req_a != cur) begin
          st.target_angle = req_a;
          st.moving_flag  = 1'b1;
          st.elapsed_ms   = '0;
        end
      end
      ModeJump: begin
        if (req_a != cur) begin
          st.target_angle  = req_a;
          st.current_angle = req_a;
          written          = 1'b1;
          done             = 1'b1;
        end
      end
      ModeHome: begin
        if (!state_i.moving_flag && (cur != home_d) && (home_a != cur)) begin
          st.target_angle = home_a;
          if (cfg_i.home_smooth) begin
            st.moving_flag = 1'b1;
            st.elapsed_ms  = '0;
          end else begin
            st.current_angle = home_a;
            written          = 1'b1;
            done             = 1'b1;
          end
        end
      end
      default: st = state_i;
    endcase
  end

  assign mirror = $signed({2'b00, cfg_i.min_angle}) + $signed({2'b00, cfg_i.max_angle})
                - $signed({2'b00, st.current_angle});

  always_comb begin
    result_o.now_angle     = st.current_angle;
    result_o.is_moving     = st.moving_flag;
    result_o.servo_written = written;
    result_o.motion_done   = done;
    if (!cfg_i.reverse_dir) begin
      result_o.drive_angle = st.current_angle;
    end else if (mirror[AngleW+1]) begin
      result_o.drive_angle = '0;
    end else if (mirror[AngleW]) begin
      result_o.drive_angle = '1;
    end else begin
      result_o.drive_angle = mirror[AngleW-1:0];
    end
  end

  assign state_o = st;

endmodule

[sv/servo_angle_slew_ramp.sv]
// Top level of the servo angle slew ramp: input register, ramp state and result register.
// Depends on sasr_pkg, sasr_cfg and sasr_step.
//
// Usage: each input beat carries a mode (tick, smooth set, immediate set or
// return to default) and a requested angle. Every accepted beat produces
// exactly one result beat with the drive angle, the logical angle, the
// moving flag and the written and done events.
// Both channels use valid and ready. An input beat is captured in the input
// register; when it advances, the ramp state is updated and the result
// is loaded into the output register at the same clock edge. One beat per
// cycle is sustained while the receiver takes each result; the only loop is
// the state update feeding the next beat.
// When the receiver stalls, the result is held and one more input beat is
// taken into the input register; after that in_ready_o drops until the
// result is taken.
// Reset clears both valid flags, loads the register defaults and sets the
// current and target angle to the home angle with no ramp in progress.
// Configuration writes must be made while idle.
module servo_angle_slew_ramp import sasr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [AngleW-1:0]   req_angle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [AngleW-1:0]   drive_angle_o,
  output logic [AngleW-1:0]   now_angle_o,
  output logic                is_moving_o,
  output logic                servo_written_o,
  output logic                motion_done_o
);

  cfg_t              cfg;
  logic              in_valid_q, in_valid_d;
  logic [1:0]        mode_q;
  logic [AngleW-1:0] req_angle_q;
  state_t            state_q, state_d;
  result_t           res_d, res_q;
  logic              out_valid_q, out_valid_d;
  logic              advance, accept;

  sasr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sasr_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .mode_i      (mode_q),
    .req_angle_i (req_angle_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign accept      = in_valid_i && in_ready_o;
  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q.current_angle <= RstAngle;
      state_q.target_angle  <= RstAngle;
      state_q.moving_flag   <= 1'b0;
      state_q.elapsed_ms    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q      <= mode_i;
      req_angle_q <= req_angle_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_angle_o   = res_q.drive_angle;
  assign now_angle_o     = res_q.now_angle;
  assign is_moving_o     = res_q.is_moving;
  assign servo_written_o = res_q.servo_written;
  assign motion_done_o   = res_q.motion_done;

endmodule
